@@ sv/i2cmb_pkg.sv @@
// Shared types and constants for the I2C master bit engine.
package i2cmb_pkg;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [7:0] POLL_LIMIT_RESET = 8'd3;
    localparam logic [3:0] BYTE_BITS        = 4'd8;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] tx_byte;
        logic       first_byte;
        logic       last_byte;
        logic       scl_level;
        logic       sda_level;
    } item_t;

    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       busy_res;
        logic       byte_done;
        logic [7:0] rx_byte;
        logic       ack_error;
        logic       order_error;
    } result_t;

endpackage

@@ sv/i2cmb_seq.sv @@
// Bit sequencer: phase state, shifter, line drive and the registered result word.
module i2cmb_seq
    import i2cmb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  item_t      item,
    input  logic [7:0] poll_limit,
    output result_t    result
);

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_ST_SDA   = 5'd1,
        PH_ST_SCL   = 5'd2,
        PH_W_DATA   = 5'd3,
        PH_W_HIGH   = 5'd4,
        PH_W_LOW    = 5'd5,
        PH_A_RELSDA = 5'd6,
        PH_A_RELSCL = 5'd7,
        PH_A_WAIT   = 5'd8,
        PH_A_POLL   = 5'd9,
        PH_R_REL    = 5'd10,
        PH_R_HIGH   = 5'd11,
        PH_R_SAMP   = 5'd12,
        PH_R_ACK    = 5'd13,
        PH_R_AHIGH  = 5'd14,
        PH_R_AWAIT  = 5'd15,
        PH_SP_LOW   = 5'd16,
        PH_SP_SCL   = 5'd17,
        PH_SP_SDA   = 5'd18
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [3:0] bit_cnt_reg, bit_cnt_next;
    logic [7:0] shifter_reg, shifter_next;
    logic [7:0] polls_reg, polls_next;
    logic       in_trans_reg, in_trans_next;
    logic       is_read_reg, is_read_next;
    logic       last_reg, last_next;
    logic       nack_reg, nack_next;
    logic       scl_drv_reg, scl_drv_next;
    logic       sda_drv_reg, sda_drv_next;
    result_t    res_reg, res_next;

    logic [3:0] cnt_inc;
    logic       done;
    logic       ack_err;
    logic       ord_err;

    assign cnt_inc = bit_cnt_reg + 4'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        bit_cnt_next  = bit_cnt_reg;
        shifter_next  = shifter_reg;
        polls_next    = polls_reg;
        in_trans_next = in_trans_reg;
        is_read_next  = is_read_reg;
        last_next     = last_reg;
        nack_next     = nack_reg;
        scl_drv_next  = scl_drv_reg;
        sda_drv_next  = sda_drv_reg;
        done          = 1'b0;
        ack_err       = 1'b0;
        ord_err       = 1'b0;

        case (phase_reg)
            PH_ST_SDA:
            begin
                sda_drv_next = 1'b1;
                phase_next   = PH_ST_SCL;
            end
            PH_ST_SCL:
            begin
                scl_drv_next = 1'b1;
                phase_next   = is_read_reg ? PH_R_REL : PH_W_DATA;
            end
            PH_W_DATA:
            begin
                sda_drv_next = ~shifter_reg[7];
                phase_next   = PH_W_HIGH;
            end
            PH_W_HIGH:
            begin
                scl_drv_next = 1'b0;
                phase_next   = PH_W_LOW;
            end
            PH_W_LOW:
            begin
                scl_drv_next = 1'b1;
                shifter_next = {shifter_reg[6:0], 1'b0};
                bit_cnt_next = cnt_inc;
                phase_next   = (cnt_inc >= BYTE_BITS) ? PH_A_RELSDA : PH_W_DATA;
            end
            PH_A_RELSDA:
            begin
                sda_drv_next = 1'b0;
                polls_next   = poll_limit;
                phase_next   = PH_A_RELSCL;
            end
            PH_A_RELSCL:
            begin
                scl_drv_next = 1'b0;
                phase_next   = PH_A_WAIT;
            end
            PH_A_WAIT:
            begin
                // no timeout on clock stretch
                if (item.scl_level)
                begin
                    phase_next = PH_A_POLL;
                end
            end
            PH_A_POLL:
            begin
                if (!item.sda_level)
                begin
                    scl_drv_next = 1'b1;
                    sda_drv_next = 1'b1;
                    if (last_reg)
                    begin
                        phase_next = PH_SP_SCL;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
                else if (polls_reg <= 8'd1)
                begin
                    // out of polls: abort with a stop
                    polls_next   = 8'd0;
                    scl_drv_next = 1'b1;
                    sda_drv_next = 1'b1;
                    nack_next    = 1'b1;
                    phase_next   = PH_SP_SCL;
                end
                else
                begin
                    polls_next = polls_reg - 8'd1;
                end
            end
            PH_R_REL:
            begin
                sda_drv_next = 1'b0;
                phase_next   = PH_R_HIGH;
            end
            PH_R_HIGH:
            begin
                scl_drv_next = 1'b0;
                phase_next   = PH_R_SAMP;
            end
            PH_R_SAMP:
            begin
                shifter_next = {shifter_reg[6:0], item.sda_level};
                scl_drv_next = 1'b1;
                bit_cnt_next = cnt_inc;
                phase_next   = (cnt_inc >= BYTE_BITS) ? PH_R_ACK : PH_R_HIGH;
            end
            PH_R_ACK:
            begin
                if (!last_reg)
                begin
                    sda_drv_next = 1'b1;
                end
                phase_next = PH_R_AHIGH;
            end
            PH_R_AHIGH:
            begin
                scl_drv_next = 1'b0;
                phase_next   = PH_R_AWAIT;
            end
            PH_R_AWAIT:
            begin
                if (item.scl_level)
                begin
                    scl_drv_next = 1'b1;
                    if (last_reg)
                    begin
                        phase_next = PH_SP_LOW;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
            end
            PH_SP_LOW:
            begin
                scl_drv_next = 1'b1;
                sda_drv_next = 1'b1;
                phase_next   = PH_SP_SCL;
            end
            PH_SP_SCL:
            begin
                scl_drv_next = 1'b0;
                phase_next   = PH_SP_SDA;
            end
            PH_SP_SDA:
            begin
                scl_drv_next  = 1'b0;
                sda_drv_next  = 1'b0;
                in_trans_next = 1'b0;
                done          = 1'b1;
                ack_err       = nack_reg;
                last_next     = 1'b0;
                nack_next     = 1'b0;
                phase_next    = PH_IDLE;
            end
            default:
            begin
                // idle, and any code with no meaning
                phase_next = PH_IDLE;
                if (item.command == CMD_WRITE || item.command == CMD_READ)
                begin
                    if (item.first_byte == in_trans_reg)
                    begin
                        // drop a misordered first flag
                        ord_err = 1'b1;
                    end
                    else
                    begin
                        is_read_next  = (item.command == CMD_READ);
                        shifter_next  = (item.command == CMD_READ) ? 8'd0 : item.tx_byte;
                        bit_cnt_next  = 4'd0;
                        last_next     = item.last_byte;
                        nack_next     = 1'b0;
                        in_trans_next = 1'b1;
                        if (item.first_byte)
                        begin
                            phase_next = PH_ST_SDA;
                        end
                        else if (item.command == CMD_READ)
                        begin
                            phase_next = PH_R_REL;
                        end
                        else
                        begin
                            phase_next = PH_W_DATA;
                        end
                    end
                end
            end
        endcase

        res_next.scl_pull_low = scl_drv_next;
        res_next.sda_pull_low = sda_drv_next;
        res_next.busy_res     = (phase_next != PH_IDLE);
        res_next.byte_done    = done;
        res_next.rx_byte      = done ? shifter_next : 8'd0;
        res_next.ack_error    = ack_err;
        res_next.order_error  = ord_err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            bit_cnt_reg  <= 4'd0;
            shifter_reg  <= 8'd0;
            polls_reg    <= 8'd0;
            in_trans_reg <= 1'b0;
            is_read_reg  <= 1'b0;
            last_reg     <= 1'b0;
            nack_reg     <= 1'b0;
            scl_drv_reg  <= 1'b0;
            sda_drv_reg  <= 1'b0;
            res_reg      <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            bit_cnt_reg  <= bit_cnt_next;
            shifter_reg  <= shifter_next;
            polls_reg    <= polls_next;
            in_trans_reg <= in_trans_next;
            is_read_reg  <= is_read_next;
            last_reg     <= last_next;
            nack_reg     <= nack_next;
            scl_drv_reg  <= scl_drv_next;
            sda_drv_reg  <= sda_drv_next;
            res_reg      <= res_next;
        end
    end

    assign result = res_reg;

endmodule

@@ sv/i2c_master_bit_engine_top.sv @@
// Top level of the I2C master bit engine: input register, handshake and poll limit register.
//
//   channel   direction   handshake              payload
//   in        input       in_valid / in_stall    command tx_byte first_byte last_byte
//                                                scl_level sda_level
//   out       output      out_valid / out_stall  scl_pull_low sda_pull_low busy_res
//                                                byte_done rx_byte ack_error order_error
//   cfg       input       cfg_write              cfg_data (ack_poll_limit)
//
// One word per clock while out_stall is low; a word passes the input and result registers.
// The sequencer step sits between the input register and the result register.
// Reset (rst_n low) empties both registers, idles the sequencer, releases both
// lines and sets the poll limit to 3.
// A stalled output holds its word; the input register keeps accepting until it is full.
module i2c_master_bit_engine_top
    import i2cmb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] command,
    input  logic [7:0] tx_byte,
    input  logic       first_byte,
    input  logic       last_byte,
    input  logic       scl_level,
    input  logic       sda_level,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       scl_pull_low,
    output logic       sda_pull_low,
    output logic       busy_res,
    output logic       byte_done,
    output logic [7:0] rx_byte,
    output logic       ack_error,
    output logic       order_error,
    input  logic       cfg_write,
    input  logic [7:0] cfg_data
);

    logic       in_vld_reg, in_vld_next;
    item_t      in_item_reg;
    logic       out_vld_reg, out_vld_next;
    logic [7:0] poll_limit_reg;
    logic       accept;
    logic       advance;
    result_t    result;

    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && out_vld_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
        else
        begin
            in_vld_next = in_vld_reg;
        end

        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_vld_next = out_vld_reg;
        end
        else
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            poll_limit_reg <= POLL_LIMIT_RESET;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_write)
            begin
                poll_limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg.command    <= command;
            in_item_reg.tx_byte    <= tx_byte;
            in_item_reg.first_byte <= first_byte;
            in_item_reg.last_byte  <= last_byte;
            in_item_reg.scl_level  <= scl_level;
            in_item_reg.sda_level  <= sda_level;
        end
    end

    i2cmb_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .item       (in_item_reg),
        .poll_limit (poll_limit_reg),
        .result     (result)
    );

    assign out_valid    = out_vld_reg;
    assign scl_pull_low = result.scl_pull_low;
    assign sda_pull_low = result.sda_pull_low;
    assign busy_res     = result.busy_res;
    assign byte_done    = result.byte_done;
    assign rx_byte      = result.rx_byte;
    assign ack_error    = result.ack_error;
    assign order_error  = result.order_error;

    a_ack_err_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ack_error) |-> byte_done)
        else $error("ack_error without byte_done");

    a_order_err_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && order_error) |-> (!byte_done && !busy_res))
        else $error("order_error on a busy or completing word");

    a_rx_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !byte_done) |-> (rx_byte == 8'd0))
        else $error("rx_byte nonzero without byte_done");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while output can drain");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the I2C master bit engine: random bus ticks against a predictor.
module testbench
    import i2cmb_pkg::*;
();

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int PHASE_WORDS = 130;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE, ST_START_SDA, ST_START_SCL, ST_WR_DATA, ST_WR_HIGH, ST_WR_LOW,
        ST_ACK_RELSDA, ST_ACK_RELSCL, ST_ACK_WAIT, ST_ACK_POLL,
        ST_RD_REL, ST_RD_HIGH, ST_RD_SAMP, ST_RD_ACK, ST_RD_AHIGH, ST_RD_AWAIT,
        ST_STOP_LOW, ST_STOP_SCL, ST_STOP_SDA
    } seq_phase_t;

    typedef struct packed {
        seq_phase_t ph;
        logic [3:0] bits;
        logic [7:0] shifter;
        logic [7:0] polls;
        logic       in_txn;
        logic       last_pending;
        logic       nack_seen;
        logic       scl_low;
        logic       sda_low;
        logic       reading;
    } engine_state_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] command = CMD_TICK;
    logic [7:0] tx_byte = 8'h00;
    logic       first_byte = 1'b0;
    logic       last_byte = 1'b0;
    logic       scl_level = 1'b1;
    logic       sda_level = 1'b1;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       byte_done;
    logic [7:0] rx_byte;
    logic       ack_error;
    logic       order_error;
    logic       cfg_write = 1'b0;
    logic [7:0] cfg_data = 8'h00;

    item_t         pending_words[$];
    result_t       expected_results[$];
    engine_state_t plan_st;
    engine_state_t check_st;
    logic [7:0]    poll_limit = POLL_LIMIT_RESET;

    int scl_hi_pct = 50;
    int ack_pct = 70;
    int cmd_noise_pct = 0;
    int words_planned = 0;
    int words_accepted = 0;
    int results_checked = 0;
    int bytes_done = 0;
    int nacks_seen = 0;
    int order_drops = 0;
    int mismatches = 0;
    int holds_wanted = 0;
    int holds_started = 0;
    int idle_cycles = 0;

    int burst_left = 0;
    int gap_left = 0;
    int stall_pct = 0;
    int pattern_left = 0;
    int long_hold_left = 0;

    always #4 clk = ~clk;

    i2c_master_bit_engine_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .tx_byte      (tx_byte),
        .first_byte   (first_byte),
        .last_byte    (last_byte),
        .scl_level    (scl_level),
        .sda_level    (sda_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .scl_pull_low (scl_pull_low),
        .sda_pull_low (sda_pull_low),
        .busy_res     (busy_res),
        .byte_done    (byte_done),
        .rx_byte      (rx_byte),
        .ack_error    (ack_error),
        .order_error  (order_error),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data)
    );

    function automatic engine_state_t engine_reset();
        engine_state_t s;
        s = '0;
        s.ph = ST_IDLE;
        return s;
    endfunction

    // Advance the sequencer by one tick and return the word it puts out.
    function automatic result_t engine_step(inout engine_state_t s, input item_t w,
                                            input logic [7:0] limit);
        result_t r;
        logic    done;
        logic    nack_out;
        logic    order_out;
        done = 1'b0;
        nack_out = 1'b0;
        order_out = 1'b0;
        case (s.ph)
            ST_START_SDA:
            begin
                s.sda_low = 1'b1;
                s.ph = ST_START_SCL;
            end
            ST_START_SCL:
            begin
                s.scl_low = 1'b1;
                s.ph = s.reading ? ST_RD_REL : ST_WR_DATA;
            end
            ST_WR_DATA:
            begin
                s.sda_low = ~s.shifter[7];
                s.ph = ST_WR_HIGH;
            end
            ST_WR_HIGH:
            begin
                s.scl_low = 1'b0;
                s.ph = ST_WR_LOW;
            end
            ST_WR_LOW:
            begin
                s.scl_low = 1'b1;
                s.shifter = {s.shifter[6:0], 1'b0};
                s.bits = s.bits + 4'd1;
                s.ph = (s.bits >= BYTE_BITS) ? ST_ACK_RELSDA : ST_WR_DATA;
            end
            ST_ACK_RELSDA:
            begin
                s.sda_low = 1'b0;
                s.polls = limit;
                s.ph = ST_ACK_RELSCL;
            end
            ST_ACK_RELSCL:
            begin
                s.scl_low = 1'b0;
                s.ph = ST_ACK_WAIT;
            end
            ST_ACK_WAIT:
            begin
                if (w.scl_level)
                    s.ph = ST_ACK_POLL;
            end
            ST_ACK_POLL:
            begin
                if (!w.sda_level)
                begin
                    s.scl_low = 1'b1;
                    s.sda_low = 1'b1;
                    if (s.last_pending)
                        s.ph = ST_STOP_SCL;
                    else
                    begin
                        s.ph = ST_IDLE;
                        done = 1'b1;
                    end
                end
                else if (s.polls <= 8'd1)
                begin
                    // out of polls: abort with a stop
                    s.polls = 8'd0;
                    s.scl_low = 1'b1;
                    s.sda_low = 1'b1;
                    s.nack_seen = 1'b1;
                    s.ph = ST_STOP_SCL;
                end
                else
                    s.polls = s.polls - 8'd1;
            end
            ST_RD_REL:
            begin
                s.sda_low = 1'b0;
                s.ph = ST_RD_HIGH;
            end
            ST_RD_HIGH:
            begin
                s.scl_low = 1'b0;
                s.ph = ST_RD_SAMP;
            end
            ST_RD_SAMP:
            begin
                s.shifter = {s.shifter[6:0], w.sda_level};
                s.scl_low = 1'b1;
                s.bits = s.bits + 4'd1;
                s.ph = (s.bits >= BYTE_BITS) ? ST_RD_ACK : ST_RD_HIGH;
            end
            ST_RD_ACK:
            begin
                if (!s.last_pending)
                    s.sda_low = 1'b1;
                s.ph = ST_RD_AHIGH;
            end
            ST_RD_AHIGH:
            begin
                s.scl_low = 1'b0;
                s.ph = ST_RD_AWAIT;
            end
            ST_RD_AWAIT:
            begin
                if (w.scl_level)
                begin
                    s.scl_low = 1'b1;
                    if (s.last_pending)
                        s.ph = ST_STOP_LOW;
                    else
                    begin
                        s.ph = ST_IDLE;
                        done = 1'b1;
                    end
                end
            end
            ST_STOP_LOW:
            begin
                s.scl_low = 1'b1;
                s.sda_low = 1'b1;
                s.ph = ST_STOP_SCL;
            end
            ST_STOP_SCL:
            begin
                s.scl_low = 1'b0;
                s.ph = ST_STOP_SDA;
            end
            ST_STOP_SDA:
            begin
                s.scl_low = 1'b0;
                s.sda_low = 1'b0;
                s.in_txn = 1'b0;
                done = 1'b1;
                nack_out = s.nack_seen;
                s.last_pending = 1'b0;
                s.nack_seen = 1'b0;
                s.ph = ST_IDLE;
            end
            default:
            begin
                s.ph = ST_IDLE;
                if (w.command == CMD_WRITE || w.command == CMD_READ)
                begin
                    // first flag must open a transaction exactly when none is open
                    if (w.first_byte == s.in_txn)
                        order_out = 1'b1;
                    else
                    begin
                        s.reading = (w.command == CMD_READ);
                        s.shifter = s.reading ? 8'h00 : w.tx_byte;
                        s.bits = 4'd0;
                        s.last_pending = w.last_byte;
                        s.nack_seen = 1'b0;
                        s.in_txn = 1'b1;
                        if (w.first_byte)
                            s.ph = ST_START_SDA;
                        else
                            s.ph = s.reading ? ST_RD_REL : ST_WR_DATA;
                    end
                end
            end
        endcase
        r.scl_pull_low = s.scl_low;
        r.sda_pull_low = s.sda_low;
        r.busy_res = (s.ph != ST_IDLE);
        r.byte_done = done;
        r.rx_byte = done ? s.shifter : 8'h00;
        r.ack_error = nack_out;
        r.order_error = order_out;
        return r;
    endfunction

    function automatic bit chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Tick word (at times a spare or random command); line levels follow what the plan waits on.
    function automatic item_t line_word();
        item_t w;
        w.command = chance(10) ? CMD_SPARE : CMD_TICK;
        if (plan_st.ph != ST_IDLE && chance(cmd_noise_pct))
            w.command = 2'($urandom_range(0, 3));
        w.tx_byte = 8'($urandom);
        w.first_byte = 1'($urandom);
        w.last_byte = 1'($urandom);
        w.scl_level = 1'($urandom);
        w.sda_level = 1'($urandom);
        if (plan_st.ph == ST_ACK_WAIT || plan_st.ph == ST_RD_AWAIT)
            w.scl_level = chance(scl_hi_pct);
        if (plan_st.ph == ST_ACK_POLL)
            w.sda_level = !chance(ack_pct);
        return w;
    endfunction

    task automatic push_word(input item_t w);
        pending_words.push_back(w);
        void'(engine_step(plan_st, w, poll_limit));
        words_planned++;
    endtask

    task automatic send_byte(input logic [1:0] cmd, input logic [7:0] data,
                             input logic first, input logic last);
        item_t w;
        w = line_word();
        w.command = cmd;
        w.tx_byte = data;
        w.first_byte = first;
        w.last_byte = last;
        push_word(w);
        while (plan_st.ph != ST_IDLE)
            push_word(line_word());
    endtask

    task automatic idle_ticks(input int n);
        for (int i = 0; i < n; i++)
            push_word(line_word());
    endtask

    task automatic random_txn();
        int         n;
        logic [1:0] cmd;
        n = chance(15) ? $urandom_range(4, 8) : $urandom_range(1, 3);
        if (plan_st.in_txn)
            send_byte(chance(50) ? CMD_WRITE : CMD_READ, 8'($urandom), 1'b0, 1'b1);
        for (int i = 0; i < n; i++)
        begin
            cmd = (i == 0 && chance(80)) || chance(50) ? CMD_WRITE : CMD_READ;
            send_byte(cmd, 8'($urandom), i == 0, i == n - 1);
            if (!plan_st.in_txn)
                break;
            if (chance(30))
                idle_ticks($urandom_range(1, 3));
        end
    endtask

    task automatic noise_burst();
        logic [1:0] cmd;
        cmd = chance(50) ? CMD_WRITE : CMD_READ;
        case ($urandom_range(0, 3))
            0: send_byte(cmd, 8'($urandom), 1'($urandom), 1'($urandom));
            1: idle_ticks($urandom_range(1, 5));
            2: send_byte(cmd, 8'($urandom), plan_st.in_txn, 1'($urandom));
            default:
            begin
                // open a transaction and leave it hanging
                if (!plan_st.in_txn)
                    send_byte(cmd, 8'($urandom), 1'b1, 1'b0);
            end
        endcase
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || expected_results.size() != 0 || in_valid)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_poll_limit(input logic [7:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= value;
        poll_limit = value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Sender: bursts of words with random gaps; predict each word as it is taken.
    always @(posedge clk or negedge rst_n)
    begin : sender
        item_t w;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                w.command = command;
                w.tx_byte = tx_byte;
                w.first_byte = first_byte;
                w.last_byte = last_byte;
                w.scl_level = scl_level;
                w.sda_level = sda_level;
                expected_results.push_back(engine_step(check_st, w, poll_limit));
                words_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    w = pending_words.pop_front();
                    command <= w.command;
                    tx_byte <= w.tx_byte;
                    first_byte <= w.first_byte;
                    last_byte <= w.last_byte;
                    scl_level <= w.scl_level;
                    sda_level <= w.sda_level;
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= chance(30) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall on a changing pattern, plus a long hold when asked.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            long_hold_left <= 0;
            pattern_left <= 0;
            stall_pct <= 0;
        end
        else if (long_hold_left != 0)
        begin
            long_hold_left <= long_hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (holds_started != holds_wanted)
        begin
            holds_started <= holds_started + 1;
            long_hold_left <= LONG_HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                pattern_left <= $urandom_range(8, 64);
                stall_pct <= chance(30) ? 0 : $urandom_range(10, 80);
            end
            else
                pattern_left <= pattern_left - 1;
            out_stall <= chance(stall_pct);
        end
    end

    // Monitor: compare each word taken from the block with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result word with no prediction pending");
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("scl_pull_low", 32'(want.scl_pull_low), 32'(scl_pull_low));
                check_field("sda_pull_low", 32'(want.sda_pull_low), 32'(sda_pull_low));
                check_field("busy_res", 32'(want.busy_res), 32'(busy_res));
                check_field("byte_done", 32'(want.byte_done), 32'(byte_done));
                check_field("rx_byte", 32'(want.rx_byte), 32'(rx_byte));
                check_field("ack_error", 32'(want.ack_error), 32'(ack_error));
                check_field("order_error", 32'(want.order_error), 32'(order_error));
                results_checked++;
                bytes_done += int'(want.byte_done);
                nacks_seen += int'(want.ack_error);
                order_drops += int'(want.order_error);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        plan_st = engine_reset();
        check_st = engine_reset();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes of the byte, ACK, NACK, stretch, reads, misordered flags.
        scl_hi_pct = 100;
        ack_pct = 100;
        idle_ticks(2);
        send_byte(CMD_WRITE, 8'hFF, 1'b0, 1'b0);
        send_byte(CMD_WRITE, 8'hFF, 1'b1, 1'b0);
        send_byte(CMD_WRITE, 8'h5A, 1'b1, 1'b0);
        scl_hi_pct = 25;
        ack_pct = 40;
        cmd_noise_pct = 30;
        send_byte(CMD_WRITE, 8'h00, 1'b0, 1'b0);
        cmd_noise_pct = 0;
        ack_pct = 100;
        send_byte(CMD_READ, 8'hA5, 1'b0, 1'b0);
        send_byte(CMD_READ, 8'h00, 1'b0, 1'b1);
        send_byte(CMD_READ, 8'hFF, 1'b1, 1'b1);
        send_byte(CMD_WRITE, 8'h80, 1'b1, 1'b1);
        ack_pct = 0;
        send_byte(CMD_WRITE, 8'h01, 1'b1, 1'b0);
        send_byte(CMD_WRITE, 8'h7F, 1'b1, 1'b1);
        push_word('{command: CMD_SPARE, tx_byte: 8'hFF, first_byte: 1'b1, last_byte: 1'b1,
                    scl_level: 1'b0, sda_level: 1'b0});
        wait_drained();

        // Random phases, each under its own poll limit.
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: write_poll_limit(8'd1);
                1: write_poll_limit(8'd255);
                2: write_poll_limit(8'd0);
                5: write_poll_limit(8'd2);
                default: write_poll_limit(8'($urandom_range(3, 254)));
            endcase
            scl_hi_pct = $urandom_range(20, 90);
            ack_pct = (p == 1) ? 8 : $urandom_range(10, 90);
            cmd_noise_pct = $urandom_range(0, 10);
            words_planned = 0;
            while (words_planned < PHASE_WORDS)
            begin
                if (chance(80))
                    random_txn();
                else
                    noise_burst();
            end
            if (p == 3)
                holds_wanted++;
            wait_drained();
        end

        repeat (10) @(posedge clk);
        $display("covered %0d ticks, %0d words checked, %0d bytes done",
                 words_accepted, results_checked, bytes_done);
        $display("%0d NACK aborts, %0d misordered commands dropped, %0d mismatches",
                 nacks_seen, order_drops, mismatches);
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
